@@ rtl/core/cxs_pkg.sv @@
`timescale 1ns / 1ps

package cxs_pkg;

   // Fixed sizes of the cipher block.
   localparam int WORD_W      = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int BLOCK_BYTES = 64;
   localparam int REM_W       = 7;   // holds 0 to 64 bytes
   localparam int POS_W       = 6;   // byte position inside a block
   localparam int ROUNDS_W    = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = ROUNDS_W'(20);

   // The "expand 32-byte k" constant as four little-endian words.
   localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
   localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
   localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
   localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_01     = 3'd0,
      CSR_KEY_23     = 3'd1,
      CSR_KEY_45     = 3'd2,
      CSR_KEY_67     = 3'd3,
      CSR_NONCE_LOW  = 3'd4,
      CSR_NONCE_HIGH = 3'd5,
      CSR_ROUNDS     = 3'd6,
      CSR_IETF       = 3'd7
   } csr_index_type;

   // Beat payloads.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [5:0] keystream_left;
   } rsp_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FINAL,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;    // take the input beat
      logic load;      // copy the initial block into the working state
      logic quarter;   // one quarter round on the working state
      logic diag;      // diagonal round rather than column round
      logic finalise;  // add the initial block and store the keystream
      logic emit;      // write the result beat
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic                empty;     // no keystream left
      logic                out_free;  // result register can take a beat
      logic [ROUNDS_W-1:0] rounds;
   } status_type;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
   } quad_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int s);
      rotl = (v << s) | (v >> (WORD_W - s));
   endfunction

   // One ChaCha quarter round.
   function automatic quad_type quarter_round(input quad_type q);
      quad_type r;
      r = q;
      r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 16);
      r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 12);
      r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 8);
      r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 7);
      return r;
   endfunction

endpackage

@@ rtl/core/cxs_ctrl.sv @@
`timescale 1ns / 1ps

module cxs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_restart,
   output logic                req_stall,
   input  cxs_pkg::status_type status,
   output cxs_pkg::cmd_type    cmd
);
   import cxs_pkg::*;

   state_type           state_ff, state_in;
   logic [ROUNDS_W-1:0] round_ff, round_in;
   logic [1:0]          qtr_ff, qtr_in;
   logic                last_round;

   assign last_round = (round_ff + ROUNDS_W'(1)) == status.rounds;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_restart || status.empty) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_LOAD: begin
            if (status.rounds == '0) begin
               state_in = ST_FINAL;
            end else begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (qtr_ff == 2'd3 && last_round) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Round and quarter counters.
   always_comb begin
      round_in = round_ff;
      qtr_in   = qtr_ff;
      if (state_ff == ST_LOAD) begin
         round_in = '0;
         qtr_in   = '0;
      end else if (state_ff == ST_ROUND) begin
         qtr_in = qtr_ff + 2'd1;
         if (qtr_ff == 2'd3) begin
            round_in = round_ff + ROUNDS_W'(1);
         end
      end
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
         end
         ST_ROUND: begin
            cmd.quarter = 1'b1;
            cmd.diag    = round_ff[0];
         end
         ST_FINAL: begin
            cmd.finalise = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         qtr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         qtr_ff   <= qtr_in;
      end
   end

endmodule

@@ rtl/core/cxs_datapath.sv @@
`timescale 1ns / 1ps

module cxs_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [cxs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cxs_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  cxs_pkg::req_type                    req_data,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output cxs_pkg::rsp_type                    rsp_data,
   input  cxs_pkg::cmd_type                    cmd,
   output cxs_pkg::status_type                 status
);
   import cxs_pkg::*;

   // Configuration registers.
   logic [63:0]         key01_ff, key23_ff, key45_ff, key67_ff, nonce_lo_ff;
   logic [WORD_W-1:0]   nonce_hi_ff;
   logic [ROUNDS_W-1:0] rounds_ff;
   logic                ietf_ff;

   // Block state.
   logic [63:0]       counter_ff, counter_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [7:0]        data_ff, data_in;
   logic [WORD_W-1:0] work_ff [BLOCK_WORDS];
   logic [WORD_W-1:0] work_in [BLOCK_WORDS];
   logic [WORD_W-1:0] ks_ff   [BLOCK_WORDS];
   logic [WORD_W-1:0] ks_in   [BLOCK_WORDS];
   logic [WORD_W-1:0] init    [BLOCK_WORDS];
   logic [WORD_W-1:0] mixed   [BLOCK_WORDS];

   // Result register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   quad_type          qr_in, qr_out;
   logic [POS_W-1:0]  pos;
   logic [WORD_W-1:0] ks_word;
   logic [7:0]        ks_byte;

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         key01_ff    <= '0;
         key23_ff    <= '0;
         key45_ff    <= '0;
         key67_ff    <= '0;
         nonce_lo_ff <= '0;
         nonce_hi_ff <= '0;
         rounds_ff   <= ROUNDS_RESET;
         ietf_ff     <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_01:     key01_ff    <= csr_wdata;
            CSR_KEY_23:     key23_ff    <= csr_wdata;
            CSR_KEY_45:     key45_ff    <= csr_wdata;
            CSR_KEY_67:     key67_ff    <= csr_wdata;
            CSR_NONCE_LOW:  nonce_lo_ff <= csr_wdata;
            CSR_NONCE_HIGH: nonce_hi_ff <= csr_wdata[WORD_W-1:0];
            CSR_ROUNDS:     rounds_ff   <= csr_wdata[ROUNDS_W-1:0];
            CSR_IETF:       ietf_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Initial block from the constant, key, counter and nonce.
   always_comb begin
      init[0]  = SIGMA_0;
      init[1]  = SIGMA_1;
      init[2]  = SIGMA_2;
      init[3]  = SIGMA_3;
      init[4]  = key01_ff[31:0];
      init[5]  = key01_ff[63:32];
      init[6]  = key23_ff[31:0];
      init[7]  = key23_ff[63:32];
      init[8]  = key45_ff[31:0];
      init[9]  = key45_ff[63:32];
      init[10] = key67_ff[31:0];
      init[11] = key67_ff[63:32];
      init[12] = counter_ff[31:0];
      if (ietf_ff) begin
         init[13] = nonce_lo_ff[31:0];
         init[14] = nonce_lo_ff[63:32];
         init[15] = nonce_hi_ff;
      end else begin
         init[13] = counter_ff[63:32];
         init[14] = nonce_lo_ff[31:0];
         init[15] = nonce_lo_ff[63:32];
      end
   end

   // The quarter round always works on fixed taps: a column
   // takes words 0, 4, 8 and 12, a diagonal words 0, 5, 10 and 15. After
   // each quarter every row turns left by one word, so the next column or
   // diagonal lands on the same taps and four quarters restore the order.
   always_comb begin
      qr_in.a = work_ff[0];
      qr_in.b = cmd.diag ? work_ff[5]  : work_ff[4];
      qr_in.c = cmd.diag ? work_ff[10] : work_ff[8];
      qr_in.d = cmd.diag ? work_ff[15] : work_ff[12];
      qr_out  = quarter_round(qr_in);
   end

   always_comb begin
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         mixed[i] = work_ff[i];
      end
      mixed[0] = qr_out.a;
      if (cmd.diag) begin
         mixed[5]  = qr_out.b;
         mixed[10] = qr_out.c;
         mixed[15] = qr_out.d;
      end else begin
         mixed[4]  = qr_out.b;
         mixed[8]  = qr_out.c;
         mixed[12] = qr_out.d;
      end
   end

   // Working state.
   always_comb begin
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         work_in[i] = work_ff[i];
         if (cmd.load) begin
            work_in[i] = init[i];
         end else if (cmd.quarter) begin
            work_in[i] = mixed[(i & ~3) | ((i + 1) & 3)];
         end
      end
   end

   // Keystream store, filled with the feed-forward sum.
   always_comb begin
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         ks_in[i] = cmd.finalise ? (work_ff[i] + init[i]) : ks_ff[i];
      end
   end

   // Next keystream byte, little endian within each word.
   assign pos     = POS_W'(REM_W'(BLOCK_BYTES) - rem_ff);
   assign ks_word = ks_ff[pos[POS_W-1:2]];
   assign ks_byte = ks_word[8*pos[1:0] +: 8];

   // Counter, byte count and held input byte.
   always_comb begin
      counter_in = counter_ff;
      rem_in     = rem_ff;
      data_in    = data_ff;
      if (cmd.accept) begin
         data_in = req_data.data_byte;
         if (req_data.restart) begin
            counter_in = '0;
            rem_in     = '0;
         end
      end else if (cmd.finalise) begin
         counter_in = counter_ff + 64'd1;
         rem_in     = REM_W'(BLOCK_BYTES);
      end else if (cmd.emit) begin
         rem_in = rem_ff - REM_W'(1);
      end
   end

   // Result beat.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_in.out_byte       = data_ff ^ ks_byte;
         rsp_in.keystream_left = POS_W'(rem_ff - REM_W'(1));
         rsp_valid_in          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         counter_ff   <= counter_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rsp_ff  <= rsp_in;
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         work_ff[i] <= work_in[i];
         ks_ff[i]   <= ks_in[i];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;
   assign status.empty    = (rem_ff == '0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.rounds   = rounds_ff;

endmodule

@@ rtl/core/chacha_stream_xor_core.sv @@
`timescale 1ns / 1ps
// Byte path: an accepted beat takes the controller from IDLE to EMIT while keystream is left,
// and EMIT writes the result beat once the result register is free. When a new block is needed,
// LOAD, ROUND and FINAL come first; ROUND runs 4 * round_count quarter rounds on the single
// quarter-round unit, one quarter round per cycle. A new byte is taken only in IDLE, after the
// previous result beat is written. Synchronous active-high reset clears the key, nonce, counter
// and keystream count; round_count returns to 20.

module chacha_stream_xor_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [cxs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cxs_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  cxs_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output cxs_pkg::rsp_type               rsp_data
);
   import cxs_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer for beats and rounds.
   cxs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_data.restart),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // Block state, round logic, keystream and result register.
   cxs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
